// ===== rtl/assert_macros.svh =====
// Assertion helpers for the scanner checker.
// Each macro samples on the rising clock edge and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner check failed");

// Next-cycle implication.
`define MSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner check failed");

`endif

// ===== rtl/mss_pkg.sv =====
`timescale 1ns / 1ps
package mss_pkg;

   // scan_status codes
   localparam logic [1:0] STATUS_UNIQUE    = 2'd0;
   localparam logic [1:0] STATUS_NONE      = 2'd1;
   localparam logic [1:0] STATUS_AMBIGUOUS = 2'd2;

   // CSR indexes
   localparam logic [1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [1:0] CSR_CARE_MASK    = 2'd2;
   localparam logic [1:0] CSR_LENGTH       = 2'd3;

   // signature bytes backed by registers
   localparam int PATTERN_REG_BYTES = 16;

   localparam int CSR_DATA_BITS = 64;
   localparam int RSP_DATA_BITS = 40;

endpackage

// ===== rtl/masked_signature_scanner_top.sv =====
`timescale 1ns / 1ps
// Result: registered, so it appears on rsp in the cycle after the transaction carrying tlast.
// Throughput: one byte per cycle while req_tready is high; the shift, compare and count update fit in one stage.
// req_tready drops only while a result is held and rsp_tready is low.
// Reset (synchronous, active high) clears scan state and the output valid and
// loads the CSRs with pattern 0, care mask all ones, length 1.
module masked_signature_scanner_top #(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int OFFSET_BITS       = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] data_byte
   input  logic                               req_tlast,   // last_byte
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mss_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,   // [1:0] scan_status,
                                                           // [33:2] match_offset, rest 0
   // CSR write port
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [mss_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int LEN_BITS = $clog2(MAX_PATTERN_BYTES + 1);

   // ---------------------------------------------------------------- CSRs
   logic [63:0] pattern_low_ff, pattern_high_ff;
   logic [15:0] care_mask_ff;
   logic [4:0]  pattern_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= 16'hFFFF;
         pattern_length_ff <= 5'd1;
      end else if (csr_we) begin
         case (csr_index)
            mss_pkg::CSR_PATTERN_LOW:  pattern_low_ff    <= csr_wdata;
            mss_pkg::CSR_PATTERN_HIGH: pattern_high_ff   <= csr_wdata;
            mss_pkg::CSR_CARE_MASK:    care_mask_ff      <= csr_wdata[15:0];
            mss_pkg::CSR_LENGTH:       pattern_length_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Length register clamped into 1..MAX_PATTERN_BYTES.
   logic [LEN_BITS-1:0] active_len;
   always_comb begin
      if (pattern_length_ff == 5'd0) begin
         active_len = LEN_BITS'(1);
      end else if (32'(pattern_length_ff) > MAX_PATTERN_BYTES) begin
         active_len = LEN_BITS'(MAX_PATTERN_BYTES);
      end else begin
         active_len = LEN_BITS'(pattern_length_ff);
      end
   end

   // ---------------------------------------------------------------- handshake
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   // The output register frees up in the same cycle it is drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // ---------------------------------------------------------------- window
   // Entry 0 holds the newest byte. Entries older than the current image are
   // never compared, since a compare needs bytes_seen >= length, so the
   // window needs no clearing between images.
   logic [7:0] window_ff [MAX_PATTERN_BYTES];
   logic [7:0] window_in [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES*8-1:0] window_flat;

   always_comb begin
      window_in[0] = req_tdata;
      for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
         window_in[i] = window_ff[i-1];
      end
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         window_flat[8*i +: 8] = window_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

   // ---------------------------------------------------------------- compare
   logic match;

   mss_matcher #(
      .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
   ) u_matcher (
      .window     (window_flat),
      .pattern    ({pattern_high_ff, pattern_low_ff}),
      .care_mask  (care_mask_ff),
      .active_len (active_len),
      .match      (match)
   );

   // ---------------------------------------------------------------- counters
   logic [OFFSET_BITS-1:0] bytes_seen_ff, bytes_seen_in;
   logic [OFFSET_BITS-1:0] seen_next;
   logic [OFFSET_BITS-1:0] first_offset_ff, first_offset_in;
   logic [OFFSET_BITS-1:0] first_next;
   logic [1:0]             matches_ff, matches_in;
   logic [1:0]             matches_next;
   logic                   site_hit;

   logic [1:0]                        status_next;
   logic [OFFSET_BITS+31:0]           offset_ext;
   logic [31:0]                       offset_next;
   logic [1:0]                        status_ff, status_in;
   logic [31:0]                       offset_ff, offset_in;

   always_comb begin
      // byte count saturates at all ones
      seen_next = (&bytes_seen_ff) ? bytes_seen_ff : bytes_seen_ff + 1'b1;
      site_hit  = match && (seen_next >= OFFSET_BITS'(active_len));

      first_next   = first_offset_ff;
      matches_next = matches_ff;
      if (site_hit) begin
         if (matches_ff == 2'd0) begin
            first_next = seen_next - OFFSET_BITS'(active_len);
         end
         if (matches_ff != 2'd2) begin
            matches_next = matches_ff + 2'd1;
         end
      end

      // result of the image if this byte ends it
      offset_ext = {32'd0, first_next};
      case (matches_next)
         2'd0: begin
            status_next = mss_pkg::STATUS_NONE;
            offset_next = '0;
         end
         2'd1: begin
            status_next = mss_pkg::STATUS_UNIQUE;
            offset_next = offset_ext[31:0];
         end
         default: begin
            status_next = mss_pkg::STATUS_AMBIGUOUS;
            offset_next = '0;
         end
      endcase

      // defaults: hold
      bytes_seen_in   = bytes_seen_ff;
      first_offset_in = first_offset_ff;
      matches_in      = matches_ff;
      status_in       = status_ff;
      offset_in       = offset_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;

      if (accept) begin
         if (req_tlast) begin
            // end of image: emit and start over
            bytes_seen_in   = '0;
            first_offset_in = '0;
            matches_in      = 2'd0;
            status_in       = status_next;
            offset_in       = offset_next;
            rsp_valid_in    = 1'b1;
         end else begin
            bytes_seen_in   = seen_next;
            first_offset_in = first_next;
            matches_in      = matches_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff   <= '0;
         first_offset_ff <= '0;
         matches_ff      <= 2'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         bytes_seen_ff   <= bytes_seen_in;
         first_offset_ff <= first_offset_in;
         matches_ff      <= matches_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      offset_ff <= offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, offset_ff, status_ff};

endmodule

// ===== rtl/mss_matcher.sv =====
`timescale 1ns / 1ps
// Parallel masked compare of the signature against the newest window.
module mss_matcher #(
   parameter int MAX_PATTERN_BYTES = 16
) (
   input  logic [MAX_PATTERN_BYTES*8-1:0]                window,
   input  logic [mss_pkg::PATTERN_REG_BYTES*8-1:0]       pattern,
   input  logic [mss_pkg::PATTERN_REG_BYTES-1:0]         care_mask,
   input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]        active_len,
   output logic                                          match
);

   localparam int LEN_BITS = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int IDX_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

   logic [MAX_PATTERN_BYTES-1:0] agree;

   for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_byte
      logic [LEN_BITS-1:0] pos;
      logic [IDX_BITS-1:0] idx;
      logic                in_use;

      // signature byte j lines up with window entry (len - 1 - j)
      assign pos    = active_len - LEN_BITS'(j + 1);
      assign idx    = pos[IDX_BITS-1:0];
      assign in_use = LEN_BITS'(j) < active_len;

      if (j < mss_pkg::PATTERN_REG_BYTES) begin : g_reg
         assign agree[j] = !in_use || !care_mask[j] ||
                           (pattern[8*j +: 8] == window[8*idx +: 8]);
      end else begin : g_wild
         assign agree[j] = 1'b1;
      end
   end

   assign match = &agree;

endmodule

// ===== rtl/mss_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mss_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [mss_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   logic rsp_stall;
   logic last_fire;
   logic not_unique;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign last_fire  = req_tvalid && req_tready && req_tlast;
   assign not_unique = rsp_tvalid && (rsp_tdata[1:0] != mss_pkg::STATUS_UNIQUE);

   // held result must not change while stalled
   `MSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // a transaction with tlast always produces a result next cycle
   `MSS_ASSERT_NEXT(a_last_gives_rsp, clock, reset, last_fire, rsp_tvalid)

   // no unused status code
   `MSS_ASSERT_NOW(a_status_legal, clock, reset, rsp_tvalid, rsp_tdata[1:0] != 2'd3)

   // offset is zero unless the match is unique
   `MSS_ASSERT_NOW(a_offset_zero, clock, reset, not_unique, rsp_tdata[39:2] == 38'd0)

   // input is only held off by a pending result
   `MSS_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

endmodule

bind masked_signature_scanner_top mss_checker u_mss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/scan_checker.sv =====
`timescale 1ns / 1ps
module scan_checker #(
   parameter int WINDOW_BYTES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] data_byte
   input  logic                              req_tlast,   // last_byte
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [mss_pkg::RSP_DATA_BITS-1:0] rsp_tdata,   // [1:0] scan_status,
                                                          // [33:2] match_offset
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [mss_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                fail_count,
   output int                                pending_count
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] offset;
   } scan_report_type;

   // own copy of the CSRs
   logic [63:0] sig_low;
   logic [63:0] sig_high;
   logic [15:0] care_bits;
   logic [4:0]  sig_len;

   // scan state
   logic [7:0]  window [WINDOW_BYTES];
   logic [31:0] byte_count;
   logic [1:0]  hit_count;
   logic [31:0] first_hit;

   scan_report_type scan_reports[$];

   task automatic clear_scan();
      for (int i = 0; i < WINDOW_BYTES; i++) window[i] = 8'd0;
      byte_count = '0;
      hit_count  = '0;
      first_hit  = '0;
   endtask

   always @(posedge clock) begin : monitor
      int unsigned  n;
      logic [127:0] sig;
      logic         hit;
      scan_report_type want;
      logic [1:0]   got_status;
      logic [31:0]  got_offset;
      logic [mss_pkg::RSP_DATA_BITS-35:0] got_pad;

      if (reset) begin
         sig_low   = '0;
         sig_high  = '0;
         care_bits = '1;
         sig_len   = 5'd1;
         clear_scan();
         scan_reports.delete();
         fail_count = 0;
      end else begin
         // result side: compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata[1:0];
            got_offset = rsp_tdata[33:2];
            got_pad    = rsp_tdata[mss_pkg::RSP_DATA_BITS-1:34];
            if (scan_reports.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = scan_reports.pop_front();
               if (got_status !== want.status) begin
                  $display("%0t: scan_status mismatch, expected %0d, actual %0d",
                           $time, want.status, got_status);
                  fail_count++;
               end
               if (got_offset !== want.offset) begin
                  $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                           $time, want.offset, got_offset);
                  fail_count++;
               end
               if (got_pad !== '0) begin
                  $display("%0t: rsp_tdata padding mismatch, expected 0, actual %h",
                           $time, got_pad);
                  fail_count++;
               end
            end
         end

         // byte side: shift window, compare site ending at the newest byte
         if (req_tvalid && req_tready) begin
            n = (sig_len == 5'd0) ? 1 :
                (sig_len > WINDOW_BYTES) ? WINDOW_BYTES : sig_len;
            sig = {sig_high, sig_low};
            for (int i = WINDOW_BYTES - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = req_tdata;
            if (byte_count != '1) byte_count++;
            if (byte_count >= n) begin
               hit = 1'b1;
               for (int j = 0; j < n; j++) begin
                  if (j < mss_pkg::PATTERN_REG_BYTES && care_bits[j] &&
                      sig[8*j +: 8] != window[n-1-j])
                     hit = 1'b0;
               end
               if (hit) begin
                  if (hit_count == 2'd0) first_hit = byte_count - 32'(n);
                  if (hit_count < 2'd2) hit_count++;
               end
            end
            if (req_tlast) begin
               case (hit_count)
                  2'd1: begin
                     want.status = mss_pkg::STATUS_UNIQUE;
                     want.offset = first_hit;
                  end
                  2'd0: begin
                     want.status = mss_pkg::STATUS_NONE;
                     want.offset = '0;
                  end
                  default: begin
                     want.status = mss_pkg::STATUS_AMBIGUOUS;
                     want.offset = '0;
                  end
               endcase
               scan_reports = {scan_reports, want};
               clear_scan();
            end
         end

         // CSR writes take effect from the next byte on; a byte taken on the
         // same edge still sees the old values
         if (csr_we) begin
            case (csr_index)
               mss_pkg::CSR_PATTERN_LOW:  sig_low   = csr_wdata;
               mss_pkg::CSR_PATTERN_HIGH: sig_high  = csr_wdata;
               mss_pkg::CSR_CARE_MASK:    care_bits = csr_wdata[15:0];
               mss_pkg::CSR_LENGTH:       sig_len   = csr_wdata[4:0];
               default: ;
            endcase
         end
      end
      pending_count = scan_reports.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the wildcard signature scanner. The scan_checker
// beside the block watches every transaction, predicts and compares.
module tb;

   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD   = 200;      // receiver hold-off that backs up the input
   localparam int GROUP_BYTES = 90;       // bytes streamed per signature setting

   // clock and synchronous reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // block inputs, all known from time zero
   logic                              req_tvalid = 1'b0;
   logic [7:0]                        req_tdata  = 8'd0;
   logic                              req_tlast  = 1'b0;
   logic                              rsp_tready = 1'b0;
   logic                              csr_we     = 1'b0;
   logic [1:0]                        csr_index  = mss_pkg::CSR_PATTERN_LOW;
   logic [mss_pkg::CSR_DATA_BITS-1:0] csr_wdata  = '0;

   // block outputs
   logic                              req_tready;
   logic                              rsp_tvalid;
   logic [mss_pkg::RSP_DATA_BITS-1:0] rsp_tdata;

   int fail_count;
   int pending_count;

   masked_signature_scanner_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   scan_checker u_scan_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // idling knobs, percent of cycles, set per phase by the stimulus
   int idle_pct  = 0;
   int stall_pct = 0;

   // long hold-off: the stimulus arms it once, the receiver counts it out
   logic hold_armed = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_left  = 0;

   // stimulus-side view of the current signature, only used to build images
   logic [127:0] stim_sig;
   logic [15:0]  stim_care;
   int           stim_len;

   logic [7:0] image_bytes[$];
   int byte_total    = 0;
   int image_total   = 0;
   int setting_total = 0;

   // Receiver: random stalls, plus one long hold-off once armed.
   always @(negedge clock) begin
      if (hold_armed && !hold_taken) begin
         hold_left  = LONG_HOLD;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // One byte transaction. Entered and left at a falling edge; tvalid stays
   // high on return so back-to-back bytes never glitch it.
   task automatic put_byte(input logic [7:0] value, input logic is_last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);   // junk while idle
         req_tlast  <= 1'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      byte_total++;
      @(negedge clock);
   endtask

   // Stream image_bytes, tlast on the final byte.
   task automatic send_image();
      for (int i = 0; i < image_bytes.size(); i++)
         put_byte(image_bytes[i], i == image_bytes.size() - 1);
      image_total++;
   endtask

   // Short hand-built image of one to three bytes.
   task automatic short_image(input int count, input logic [7:0] b0, b1, b2);
      image_bytes.delete();
      image_bytes = {image_bytes, b0};
      if (count > 1) image_bytes = {image_bytes, b1};
      if (count > 2) image_bytes = {image_bytes, b2};
      send_image();
   endtask

   // Let every outstanding result drain, plus the output stage.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Leaves csr_we high; configure() lowers it once after the last write.
   task automatic put_reg(input logic [1:0] index,
                          input logic [mss_pkg::CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // Write all four CSRs; junk in the unused upper bits checks they are ignored.
   task automatic configure(input logic [63:0] low, high, input logic [15:0] care,
                            input logic [4:0] len);
      put_reg(mss_pkg::CSR_PATTERN_LOW, low);
      put_reg(mss_pkg::CSR_PATTERN_HIGH, high);
      put_reg(mss_pkg::CSR_CARE_MASK, {16'($urandom), $urandom(), care});
      put_reg(mss_pkg::CSR_LENGTH, {27'($urandom), $urandom(), len});
      csr_we    <= 1'b0;
      stim_sig  = {high, low};
      stim_care = care;
      stim_len  = (len == 5'd0) ? 1 : (len > 5'd16) ? 16 : int'(len);
      setting_total++;
   endtask

   initial begin : stimulus
      int k;
      int n;
      int j;
      int img_len;
      int copies;
      int at;
      int start_bytes;
      logic [4:0]  len_w;
      logic [15:0] care_w;
      logic [63:0] low_w;
      logic [63:0] high_w;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part, reset CSRs: one-byte signature 0x00, must match ---
      short_image(1, 8'h00, 8'h00, 8'h00);   // unique match at offset 0
      short_image(3, 8'hFF, 8'h00, 8'h00);   // two matches: ambiguous
      short_image(3, 8'hFF, 8'h01, 8'h00);   // unique match at the last byte
      short_image(1, 8'hAB, 8'h00, 8'h00);   // no match
      drain();

      // length zero acts as one; all bytes wildcard
      configure('1, '1, 16'h0000, 5'd0);
      short_image(1, 8'h5A, 8'h00, 8'h00);   // any single byte matches
      short_image(2, 8'h11, 8'h22, 8'h00);   // every site matches: ambiguous
      drain();

      // full sixteen-byte signature, image shorter than the signature
      configure(64'h0706050403020100, 64'h0F0E0D0C0B0A0908, 16'hFFFF, 5'd16);
      short_image(3, 8'h00, 8'h01, 8'h02);   // short image: no match

      // --- random part: four idling phases, several settings each ---
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 85; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 85; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase

         for (int grp = 0; grp < 4; grp++) begin
            drain();
            k = setting_total;
            // lengths cycle through the extremes, out-of-range codes and mid values
            case (k % 8)
               0: len_w = 5'd1;
               1: len_w = 5'd16;
               2: len_w = 5'd0;
               3: len_w = 5'd31;
               4: len_w = 5'($urandom_range(15, 2));
               5: len_w = 5'($urandom_range(31, 17));
               6: len_w = 5'($urandom_range(4, 1));
               default: len_w = 5'($urandom_range(16, 1));
            endcase
            case (k % 4)
               0: care_w = 16'hFFFF;
               1: care_w = 16'h0000;
               default: care_w = 16'($urandom);
            endcase
            case (k % 6)
               0: begin low_w = '0; high_w = '0; end
               5: begin low_w = '1; high_w = '1; end
               default: begin
                  low_w  = {$urandom(), $urandom()};
                  high_w = {$urandom(), $urandom()};
               end
            endcase
            configure(low_w, high_w, care_w, len_w);

            start_bytes = byte_total;
            while (byte_total - start_bytes < GROUP_BYTES) begin
               n = stim_len;
               // mostly long enough to hold the signature, sometimes too short
               if ($urandom_range(9) == 0) img_len = $urandom_range(n, 1);
               else img_len = $urandom_range(n + 24, n);

               // filler: half random bytes, half drawn from the signature
               // so that partial matches are common
               image_bytes.delete();
               for (int i = 0; i < img_len; i++) begin
                  if ($urandom_range(1) == 1) begin
                     image_bytes = {image_bytes, 8'($urandom)};
                  end else begin
                     j = $urandom_range(n - 1, 0);
                     image_bytes = {image_bytes, stim_sig[8*j +: 8]};
                  end
               end

               // plant zero, one or two copies; wildcard bytes get random content
               case ($urandom_range(3))
                  0: copies = 0;
                  3: copies = 2;
                  default: copies = 1;
               endcase
               if (img_len >= n) begin
                  for (int c = 0; c < copies; c++) begin
                     at = $urandom_range(img_len - n, 0);
                     for (int b = 0; b < n; b++)
                        image_bytes[at+b] = stim_care[b] ? stim_sig[8*b +: 8] : 8'($urandom);
                  end
               end
               send_image();
            end
         end

         // back-pressure: receiver holds off while short images keep coming,
         // so a result sits in the output stage and the input stalls
         if (phase == 0) begin
            drain();
            configure({$urandom(), $urandom()}, {$urandom(), $urandom()}, 16'h0000, 5'd1);
            hold_armed = 1'b1;
            repeat (40)
               short_image($urandom_range(3, 1), 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end

      // --- wind down ---
      drain();
      repeat (4) @(negedge clock);

      $display("Scanned %0d bytes in %0d images under %0d signature settings,",
               byte_total, image_total, setting_total);
      $display("across idle-free, sender-idle, receiver-stall and mixed phases %s",
               "with one long hold-off.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Cycle counter guarding against a hung handshake.
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles, %0d results outstanding", cycle_count, pending_count);
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mss_pkg.sv
rtl/mss_matcher.sv
rtl/masked_signature_scanner_top.sv
rtl/mss_checker.sv
test/scan_checker.sv
test/tb.sv
